// ===== hw/rtl/focl_pkg.sv =====
// Package for the FOC current and speed loop: command codes, register indices, scaling constants and the sine table.
// Used by foc_current_speed_loop. Depends on nothing else.
package focl_pkg;

  localparam logic [1:0] CMD_STEP  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_STOP  = 2'd2;
  localparam logic [1:0] CMD_RSVD  = 2'd3;

  localparam logic [2:0] REG_MODE     = 3'd0;
  localparam logic [2:0] REG_SPEED_SP = 3'd1;
  localparam logic [2:0] REG_IQ_CMD   = 3'd2;
  localparam logic [2:0] REG_SPD_KP   = 3'd3;
  localparam logic [2:0] REG_SPD_KI   = 3'd4;
  localparam logic [2:0] REG_CUR_KP   = 3'd5;
  localparam logic [2:0] REG_CUR_KI   = 3'd6;
  localparam logic [2:0] REG_CUR_LIM  = 3'd7;

  localparam int          BETA_GAIN   = 18919;
  localparam int          SPEED_SCALE = 60;
  localparam logic signed [31:0] INT_LIMIT = 32'sd983040000;

  // Quarter-wave sine polynomial, q15 in and out, evaluated at elaboration for table contents.
  function automatic logic signed [15:0] quarter_sine(input longint x);
    longint x2;
    longint t;
    x2 = (x * x) >>> 15;
    t  = (2611 * x2) >>> 15;
    t  = ((21167 - t) * x2) >>> 15;
    t  = ((51472 - t) * x) >>> 15;
    if (t < 0) t = 0;
    if (t > 32767) t = 32767;
    return 16'(t);
  endfunction

  // Sine table entry for an index of tbits bits.
  function automatic logic signed [15:0] sine_entry(input int idx, input int tbits);
    int     qbits;
    int     quad;
    longint x;
    logic signed [15:0] v;
    qbits = tbits - 2;
    quad  = (idx >> qbits) & 3;
    x     = longint'(idx & ((1 << qbits) - 1)) << (15 - qbits);
    if ((quad & 1) != 0) x = 32768 - x;
    v = quarter_sine(x);
    return ((quad & 2) != 0) ? -v : v;
  endfunction

endpackage

// ===== hw/rtl/foc_current_speed_loop.sv =====
// Top level of the FOC current and speed loop: one result per input transaction.
// Depends on focl_pkg for codes and the sine table function.
//
// Channel   Dir  Handshake         Content
// s_axis    in   tvalid/tready     tuser command; tdata phase currents, angle, estimated speed
// m_axis    out  tvalid/tready     tdata voltages, d/q currents, speed value; tuser running
// cfg       in   cfg_we            register index and write data
//
// A control step runs the sequencer states from S_BETA to S_B2, skipping S_SKI and S_SKP in current
// mode: one 32x18 signed multiplier is shared by every product of the step.
// Start, stop, reserved commands and steps while idle go from S_CMD straight to S_DONE.
// The block takes no input while a step runs or while a result waits in the output register.
// rst is synchronous and resets the sequencer, run flag, integrators and config registers.
module foc_current_speed_loop #(
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] command
  input  logic [1:0]  s_axis_tuser,
  // [15:0] phase_a_current, [31:16] phase_b_current, [47:32] rotor_angle,
  // [63:48] est_speed
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] voltage_alpha, [31:16] voltage_beta, [47:32] voltage_d, [63:48] voltage_q,
  // [79:64] current_d, [95:80] current_q, [102:96] speed_value, [103] zero
  output logic [103:0] m_axis_tdata,
  // [0] running
  output logic        m_axis_tuser,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);
  import focl_pkg::*;

  localparam int TBL_SIZE = 1 << SINE_TABLE_BITS;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_CMD  = 5'd1;
  localparam logic [4:0] S_BETA = 5'd2;
  localparam logic [4:0] S_D1   = 5'd3;
  localparam logic [4:0] S_D2   = 5'd4;
  localparam logic [4:0] S_Q1   = 5'd5;
  localparam logic [4:0] S_Q2   = 5'd6;
  localparam logic [4:0] S_SPD  = 5'd7;
  localparam logic [4:0] S_SKI  = 5'd8;
  localparam logic [4:0] S_SKP  = 5'd9;
  localparam logic [4:0] S_DKI  = 5'd10;
  localparam logic [4:0] S_QKI  = 5'd11;
  localparam logic [4:0] S_DKP  = 5'd12;
  localparam logic [4:0] S_QKP  = 5'd13;
  localparam logic [4:0] S_A1   = 5'd14;
  localparam logic [4:0] S_A2   = 5'd15;
  localparam logic [4:0] S_B1   = 5'd16;
  localparam logic [4:0] S_B2   = 5'd17;
  localparam logic [4:0] S_DONE = 5'd18;

  logic signed [15:0] sine_rom [TBL_SIZE];
  for (genvar g = 0; g < TBL_SIZE; g++) begin : g_rom
    assign sine_rom[g] = sine_entry(g, SINE_TABLE_BITS);
  end

  // Configuration registers.
  logic               control_mode;
  logic signed [15:0] speed_setpoint, iq_command;
  logic [14:0]        speed_prop_gain, speed_int_gain, current_prop_gain, current_int_gain;
  logic [14:0]        current_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      control_mode      <= 1'b1;
      speed_setpoint    <= '0;
      iq_command        <= '0;
      speed_prop_gain   <= '0;
      speed_int_gain    <= '0;
      current_prop_gain <= '0;
      current_int_gain  <= '0;
      current_limit     <= 15'h7FFF;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MODE:     control_mode      <= cfg_wdata[0];
        REG_SPEED_SP: speed_setpoint    <= cfg_wdata;
        REG_IQ_CMD:   iq_command        <= cfg_wdata;
        REG_SPD_KP:   speed_prop_gain   <= cfg_wdata[14:0];
        REG_SPD_KI:   speed_int_gain    <= cfg_wdata[14:0];
        REG_CUR_KP:   current_prop_gain <= cfg_wdata[14:0];
        REG_CUR_KI:   current_int_gain  <= cfg_wdata[14:0];
        REG_CUR_LIM:  current_limit     <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  function automatic logic signed [15:0] sat16(input logic signed [49:0] v);
    if (v > 50'sd32767) return 16'sh7FFF;
    if (v < -50'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic signed [31:0] clamp_int(input logic signed [49:0] v);
    if (v > 50'(INT_LIMIT)) return INT_LIMIT;
    if (v < -50'(INT_LIMIT)) return -INT_LIMIT;
    return v[31:0];
  endfunction

  logic [4:0]  state;
  logic [1:0]  cmd;
  logic signed [15:0] ia, ib, obs, s_val, c_val;
  logic [15:0] angle;
  logic signed [15:0] ibeta, id, iq, derr, qerr, vd, vq, va;
  logic signed [6:0]  spd;
  logic signed [15:0] serr;
  logic signed [31:0] d_integrator, q_integrator, speed_integrator;
  logic        run_flag;
  logic signed [49:0] acc;
  logic [103:0] out_data;
  logic        out_run;
  logic        out_valid;

  // Shared multiplier operands, selected by the sequencer.
  logic signed [31:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [49:0] prod;

  logic [SINE_TABLE_BITS-1:0] sidx, cidx;
  assign sidx = angle[15 -: SINE_TABLE_BITS];
  assign cidx = sidx + SINE_TABLE_BITS'(TBL_SIZE >> 2);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_BETA: begin mul_a = 32'(ia) + 32'(ib) + 32'(ib); mul_b = 18'(BETA_GAIN); end
      S_D1:   begin mul_a = 32'(ia);    mul_b = 18'(c_val); end
      S_D2:   begin mul_a = 32'(ibeta); mul_b = 18'(s_val); end
      S_Q1:   begin mul_a = -32'(ia);   mul_b = 18'(s_val); end
      S_Q2:   begin mul_a = 32'(ibeta); mul_b = 18'(c_val); end
      S_SPD:  begin mul_a = 32'(obs);   mul_b = 18'(SPEED_SCALE); end
      S_SKI:  begin mul_a = 32'(serr);  mul_b = 18'({1'b0, speed_int_gain}); end
      S_SKP:  begin mul_a = 32'(serr);  mul_b = 18'({1'b0, speed_prop_gain}); end
      S_DKI:  begin mul_a = 32'(derr);  mul_b = 18'({1'b0, current_int_gain}); end
      S_QKI:  begin mul_a = 32'(qerr);  mul_b = 18'({1'b0, current_int_gain}); end
      S_DKP:  begin mul_a = 32'(derr);  mul_b = 18'({1'b0, current_prop_gain}); end
      S_QKP:  begin mul_a = 32'(qerr);  mul_b = 18'({1'b0, current_prop_gain}); end
      S_A1:   begin mul_a = 32'(vd);    mul_b = 18'(c_val); end
      S_A2:   begin mul_a = -32'(vq);   mul_b = 18'(s_val); end
      S_B1:   begin mul_a = 32'(vd);    mul_b = 18'(s_val); end
      S_B2:   begin mul_a = 32'(vq);    mul_b = 18'(c_val); end
      default: ;
    endcase
    prod = 50'(mul_a) * 50'(mul_b);
  end

  logic signed [49:0] sum2, lim;
  logic signed [15:0] new_tgt;
  assign sum2 = acc + prod;
  assign lim  = 50'($signed({1'b0, current_limit}));
  always_comb begin
    // Speed PI output: proportional product plus integrator, clamped to the limit.
    logic signed [49:0] t;
    t = prod + 50'(speed_integrator >>> 15);
    if (t > lim) new_tgt = 16'(lim);
    else if (t < -lim) new_tgt = 16'(-lim);
    else new_tgt = t[15:0];
  end

  assign s_axis_tready = (state == S_IDLE) && !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      run_flag <= 1'b0;
      out_valid <= 1'b0;
      d_integrator <= '0;
      q_integrator <= '0;
      speed_integrator <= '0;
    end else begin
      if (out_valid && m_axis_tready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          cmd   <= s_axis_tuser;
          ia    <= s_axis_tdata[15:0];
          ib    <= s_axis_tdata[31:16];
          angle <= s_axis_tdata[47:32];
          obs   <= s_axis_tdata[63:48];
          state <= S_CMD;
        end
        S_CMD: begin
          s_val <= sine_rom[sidx];
          c_val <= sine_rom[cidx];
          out_data <= '0;
          if (cmd == CMD_START) begin
            if (!run_flag) begin
              d_integrator <= '0;
              q_integrator <= '0;
              speed_integrator <= '0;
            end
            run_flag <= 1'b1;
            out_run <= 1'b1;
            state <= S_DONE;
          end else if (cmd == CMD_STOP) begin
            run_flag <= 1'b0;
            out_run <= 1'b0;
            state <= S_DONE;
          end else if (cmd != CMD_STEP || !run_flag) begin
            out_run <= run_flag;
            state <= S_DONE;
          end else begin
            state <= S_BETA;
          end
        end
        S_BETA: begin ibeta <= sat16(prod >>> 15); state <= S_D1; end
        S_D1:   begin acc <= prod; state <= S_D2; end
        S_D2:   begin id <= sat16(sum2 >>> 15); state <= S_Q1; end
        S_Q1:   begin acc <= prod; state <= S_Q2; end
        S_Q2:   begin iq <= sat16(sum2 >>> 15); state <= S_SPD; end
        S_SPD: begin
          spd  <= 7'(prod >>> 15);
          serr <= sat16(50'(speed_setpoint) - (prod >>> 15));
          state <= control_mode ? S_SKI : S_DKI;
          if (!control_mode) begin
            derr <= sat16(-50'(id));
            qerr <= sat16(50'(iq_command) - 50'(iq));
          end
        end
        S_SKI: begin
          speed_integrator <= clamp_int(50'(speed_integrator) + prod);
          state <= S_SKP;
        end
        S_SKP: begin
          derr <= sat16(-50'(id));
          qerr <= sat16(50'(new_tgt) - 50'(iq));
          state <= S_DKI;
        end
        S_DKI: begin d_integrator <= clamp_int(50'(d_integrator) + prod); state <= S_QKI; end
        S_QKI: begin q_integrator <= clamp_int(50'(q_integrator) + prod); state <= S_DKP; end
        S_DKP: begin
          vd <= sat16((prod >>> 8) + 50'(d_integrator >>> 15));
          state <= S_QKP;
        end
        S_QKP: begin
          vq <= sat16((prod >>> 8) + 50'(q_integrator >>> 15));
          state <= S_A1;
        end
        S_A1: begin acc <= prod; state <= S_A2; end
        S_A2: begin va <= sat16(sum2 >>> 15); state <= S_B1; end
        S_B1: begin acc <= prod; state <= S_B2; end
        S_B2: begin
          out_data <= {1'b0, spd, iq, id, vq, vd, sat16(sum2 >>> 15), va};
          out_run <= 1'b1;
          state <= S_DONE;
        end
        S_DONE: begin out_valid <= 1'b1; state <= S_IDLE; end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_run;

  a_ready_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !s_axis_tready) else $error("input taken while result pending");
  a_idle_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |=> out_valid) else $error("result not presented");
  a_int_lim: assert property (@(posedge clk) disable iff (rst)
    (d_integrator <= INT_LIMIT) && (d_integrator >= -INT_LIMIT))
    else $error("d integrator beyond limit");
endmodule
